// ===== src/sla_pkg.sv =====
// ----------------------------------------------------------------------------
// sla_pkg
// Shared types and constants for the symbol lookup by address block.
// ----------------------------------------------------------------------------
package sla_pkg;

  // Number of entries in the symbol table.
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int ADDR_W      = 32;
  localparam int BIND_W      = 4;

  // Bindings below this value are preferred among entries sharing an address.
  localparam logic [BIND_W-1:0] BIND_LIMIT = 4'd3;

  // Command codes.
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  // One table entry as held in the memory.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [BIND_W-1:0] binding;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Lookup sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK0,
    ST_BIS,
    ST_BCMP,
    ST_BASE,
    ST_WALK
  } state_t;

endpackage

// ===== src/sla_ram.sv =====
// ----------------------------------------------------------------------------
// sla_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sla_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 36,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/symbol_lookup_by_address.sv =====
// ----------------------------------------------------------------------------
// symbol_lookup_by_address
// Symbol table of start addresses with bindings, searched for the floor entry.
// ----------------------------------------------------------------------------
// Usage. A transaction is accepted on a rising edge where start is high and
// busy is low; in_mode selects clear, append or lookup. Every transaction
// gives exactly one result, shown on the out_ ports for one cycle while
// out_valid is high. The receiver cannot stall, so the result is simply
// taken on that cycle.
// Clear and append finish at once: the result appears in the cycle after
// acceptance and busy never rises, so such transactions may follow every
// cycle. A lookup raises busy while it runs. It reads entry 0, then bisects
// the table with one memory read and one compare per step, reads the floor
// entry and walks back one entry a cycle over earlier entries with the same
// address. A lookup lasts longer for a fuller table and for each entry
// walked, as the entry memory has a single read port.
// After reset the table is empty; the memory is not cleared, as only entries
// below the fill count are ever read.
// ----------------------------------------------------------------------------
module symbol_lookup_by_address (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_addr_value,
  input  logic [3:0]  in_binding,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [7:0]  out_entry_index,
  output logic [31:0] out_offset
);

  localparam int IDX_W  = sla_pkg::IDX_W;
  localparam int CNT_W  = sla_pkg::CNT_W;
  localparam int ADDR_W = sla_pkg::ADDR_W;

  // Sequencer state and fill count.
  sla_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // Lookup datapath registers.
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [IDX_W-1:0]  lo_r, lo_nxt;
  logic [CNT_W-1:0]  hi_r, hi_nxt;
  logic [IDX_W-1:0]  mid_r, mid_nxt;
  logic [IDX_W-1:0]  j_r, j_nxt;
  logic [IDX_W-1:0]  pick_r, pick_nxt;

  // Result registers.
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [7:0]        out_index_r;
  logic [ADDR_W-1:0] out_offset_r;

  // Result produced this cycle.
  logic              res_valid;
  logic [1:0]        res_status;
  logic [IDX_W-1:0]  res_index;
  logic [ADDR_W-1:0] res_offset;

  // Memory port signals.
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  sla_pkg::entry_t      wr_entry;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [sla_pkg::ENTRY_W-1:0] rd_raw;
  sla_pkg::entry_t      rd_entry;

  logic             accept;
  logic [CNT_W-1:0] lo_plus1;
  logic [CNT_W-1:0] mid_sum;
  logic [IDX_W-1:0] walk_pick;

  assign accept   = start && (state_r == sla_pkg::ST_IDLE);
  assign busy     = (state_r != sla_pkg::ST_IDLE);
  assign rd_entry = sla_pkg::entry_t'(rd_raw);
  assign wr_entry = '{addr: in_addr_value, binding: in_binding};

  // Bisection arithmetic: the sum of the bounds fits in the count width, as
  // lo stays below the depth and hi never exceeds it.
  assign lo_plus1 = {1'b0, lo_r} + CNT_W'(1);
  assign mid_sum  = {1'b0, lo_r} + hi_r;

  // During the walk an entry with a preferred binding replaces the pick.
  assign walk_pick = (rd_entry.binding < sla_pkg::BIND_LIMIT) ? j_r : pick_r;

  sla_ram #(
    .DEPTH (sla_pkg::TABLE_DEPTH),
    .WIDTH (sla_pkg::ENTRY_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sla_pkg::ST_IDLE: begin
        if (accept && (in_mode == sla_pkg::MODE_LOOKUP) && (count_r != '0)) begin
          state_nxt = sla_pkg::ST_CHK0;
        end
      end
      sla_pkg::ST_CHK0: begin
        if (addr_r < rd_entry.addr) begin
          state_nxt = sla_pkg::ST_IDLE;
        end else begin
          state_nxt = sla_pkg::ST_BIS;
        end
      end
      sla_pkg::ST_BIS: begin
        if (lo_plus1 < hi_r) begin
          state_nxt = sla_pkg::ST_BCMP;
        end else begin
          state_nxt = sla_pkg::ST_BASE;
        end
      end
      sla_pkg::ST_BCMP: begin
        state_nxt = sla_pkg::ST_BIS;
      end
      sla_pkg::ST_BASE: begin
        if ((rd_entry.addr == '0) || (lo_r == '0)) begin
          state_nxt = sla_pkg::ST_IDLE;
        end else begin
          state_nxt = sla_pkg::ST_WALK;
        end
      end
      sla_pkg::ST_WALK: begin
        if ((rd_entry.addr != base_r) || (j_r == '0)) begin
          state_nxt = sla_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sla_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath, memory control and result generation.
  always_comb begin
    count_nxt  = count_r;
    addr_nxt   = addr_r;
    base_nxt   = base_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    j_nxt      = j_r;
    pick_nxt   = pick_r;
    wr_en      = 1'b0;
    wr_addr    = count_r[IDX_W-1:0];
    rd_en      = 1'b0;
    rd_addr    = '0;
    res_valid  = 1'b0;
    res_status = sla_pkg::STATUS_OK;
    res_index  = '0;
    res_offset = '0;
    case (state_r)
      sla_pkg::ST_IDLE: begin
        if (accept) begin
          res_valid = 1'b1;
          case (in_mode)
            sla_pkg::MODE_CLEAR: begin
              count_nxt = '0;
            end
            sla_pkg::MODE_APPEND: begin
              if (count_r >= CNT_W'(sla_pkg::TABLE_DEPTH)) begin
                res_status = sla_pkg::STATUS_FULL;
              end else begin
                wr_en     = 1'b1;
                res_index = count_r[IDX_W-1:0];
                count_nxt = count_r + CNT_W'(1);
              end
            end
            sla_pkg::MODE_LOOKUP: begin
              addr_nxt = in_addr_value;
              if (count_r == '0) begin
                res_status = sla_pkg::STATUS_NOT_FOUND;
              end else begin
                // The result follows once the search has finished.
                res_valid = 1'b0;
                rd_en     = 1'b1;
                rd_addr   = '0;
              end
            end
            default: begin
              res_status = sla_pkg::STATUS_NOT_FOUND;
            end
          endcase
        end
      end
      sla_pkg::ST_CHK0: begin
        if (addr_r < rd_entry.addr) begin
          res_valid  = 1'b1;
          res_status = sla_pkg::STATUS_NOT_FOUND;
        end else begin
          lo_nxt = '0;
          hi_nxt = count_r;
        end
      end
      sla_pkg::ST_BIS: begin
        rd_en = 1'b1;
        if (lo_plus1 < hi_r) begin
          mid_nxt = mid_sum[CNT_W-1:1];
          rd_addr = mid_sum[CNT_W-1:1];
        end else begin
          rd_addr = lo_r;
        end
      end
      sla_pkg::ST_BCMP: begin
        if (rd_entry.addr > addr_r) begin
          hi_nxt = {1'b0, mid_r};
        end else if (rd_entry.addr < addr_r) begin
          lo_nxt = mid_r;
        end else begin
          // Exact match ends the bisection: closing hi onto lo makes the
          // next step read the floor entry.
          lo_nxt = mid_r;
          hi_nxt = {1'b0, mid_r} + CNT_W'(1);
        end
      end
      sla_pkg::ST_BASE: begin
        base_nxt = rd_entry.addr;
        pick_nxt = lo_r;
        if (rd_entry.addr == '0) begin
          res_valid  = 1'b1;
          res_status = sla_pkg::STATUS_NOT_FOUND;
        end else if (lo_r == '0) begin
          res_valid  = 1'b1;
          res_index  = lo_r;
          res_offset = addr_r - rd_entry.addr;
        end else begin
          rd_en   = 1'b1;
          rd_addr = lo_r - IDX_W'(1);
          j_nxt   = lo_r - IDX_W'(1);
        end
      end
      sla_pkg::ST_WALK: begin
        if (rd_entry.addr != base_r) begin
          res_valid  = 1'b1;
          res_index  = pick_r;
          res_offset = addr_r - base_r;
        end else if (j_r == '0) begin
          res_valid  = 1'b1;
          res_index  = walk_pick;
          res_offset = addr_r - base_r;
        end else begin
          pick_nxt = walk_pick;
          rd_en    = 1'b1;
          rd_addr  = j_r - IDX_W'(1);
          j_nxt    = j_r - IDX_W'(1);
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sla_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= res_valid;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    base_r       <= base_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    j_r          <= j_nxt;
    pick_r       <= pick_nxt;
    out_status_r <= res_status;
    out_index_r  <= 8'(res_index);
    out_offset_r <= res_offset;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_index = out_index_r;
  assign out_offset      = out_offset_r;

endmodule
